@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/ael_pkg.sv @@
// ----------------------------------------------------------------------------
// ael_pkg
// Shared types and constants of the arithmetic expression lexer.
// ----------------------------------------------------------------------------
package ael_pkg;

    localparam int MAX_TEXT_LEN = 65536;
    localparam logic [15:0] POS_LIMIT = ((MAX_TEXT_LEN - 1) > 65535) ?
        16'hFFFF : 16'(MAX_TEXT_LEN - 1);
    localparam logic [15:0] LEN_LIMIT = 16'hFFFF;

    // Token queue; depth must be a power of two (pointers wrap naturally)
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        KIND_OP      = 2'd0,
        KIND_BRACKET = 2'd1,
        KIND_NUMBER  = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic [7:0]  first;
        logic        last;
    } token_t;

endpackage

@@ hw/rtl/ael_front.sv @@
// ----------------------------------------------------------------------------
// ael_front
// Scanner: classifies each byte, tracks the pending number, writes tokens.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ael_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [7:0]            text_byte,
    output logic                  full,
    input  logic                  q_full,
    output logic                  q_wr_en,
    output ael_pkg::token_t       q_wr_data
);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_INT  = 2'd1,
        MODE_FRAC = 2'd2,
        MODE_HALT = 2'd3
    } mode_t;

    mode_t           mode_reg, mode_next;
    logic [15:0]     pos_reg, pos_next;
    logic [15:0]     nstart_reg, nstart_next;
    logic [15:0]     nlen_reg, nlen_next;
    logic [7:0]      nfirst_reg, nfirst_next;
    logic            pend_valid_reg, pend_valid_next;
    ael_pkg::token_t pend_tok_reg, pend_tok_next;

    logic            accept;
    logic            is_digit, is_space, is_op, is_brk, in_number;
    logic            num_emit, cls_emit, two_tok;
    logic [15:0]     pos_inc, len_inc;
    ael_pkg::token_t num_tok, cls_tok, first_tok;

    assign full   = pend_valid_reg || q_full;
    assign accept = push && !full;

    assign is_digit  = (text_byte >= ael_pkg::CH_ZERO) && (text_byte <= ael_pkg::CH_NINE);
    assign is_space  = (text_byte == ael_pkg::CH_SPACE) ||
                       ((text_byte >= ael_pkg::CH_TAB) && (text_byte <= ael_pkg::CH_CR));
    assign is_op     = (text_byte == ael_pkg::CH_PLUS) || (text_byte == ael_pkg::CH_MINUS) ||
                       (text_byte == ael_pkg::CH_STAR) || (text_byte == ael_pkg::CH_SLASH);
    assign is_brk    = (text_byte == ael_pkg::CH_LPAR) || (text_byte == ael_pkg::CH_RPAR);
    assign in_number = (mode_reg == MODE_INT) || (mode_reg == MODE_FRAC);

    assign pos_inc = (pos_reg < ael_pkg::POS_LIMIT) ? pos_reg + 16'd1 : pos_reg;
    assign len_inc = (nlen_reg != ael_pkg::LEN_LIMIT) ? nlen_reg + 16'd1 : nlen_reg;

    always_comb
    begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        nstart_next = nstart_reg;
        nlen_next   = nlen_reg;
        nfirst_next = nfirst_reg;
        num_emit    = 1'b0;
        cls_emit    = 1'b0;

        num_tok.kind   = ael_pkg::KIND_NUMBER;
        num_tok.start  = nstart_reg;
        num_tok.length = nlen_reg;
        num_tok.first  = nfirst_reg;
        num_tok.last   = 1'b1;

        cls_tok.kind   = ael_pkg::KIND_ERROR;
        cls_tok.start  = pos_reg;
        cls_tok.length = 16'd1;
        cls_tok.first  = text_byte;
        cls_tok.last   = 1'b1;

        if (text_byte == ael_pkg::CH_NUL)
        begin
            // End of text: flush the number and restart at offset zero
            num_emit    = in_number;
            mode_next   = MODE_IDLE;
            pos_next    = 16'd0;
            nstart_next = 16'd0;
            nlen_next   = 16'd0;
            nfirst_next = 8'd0;
        end
        else if (mode_reg == MODE_HALT)
        begin
            // Drop everything until end of text
        end
        else if (in_number && is_digit)
        begin
            nlen_next = len_inc;
            pos_next  = pos_inc;
        end
        else if ((mode_reg == MODE_INT) && (text_byte == ael_pkg::CH_POINT))
        begin
            nlen_next = len_inc;
            mode_next = MODE_FRAC;
            pos_next  = pos_inc;
        end
        else
        begin
            num_emit  = in_number;
            mode_next = MODE_IDLE;
            pos_next  = pos_inc;
            if (is_space)
            begin
            end
            else if (is_op)
            begin
                cls_emit     = 1'b1;
                cls_tok.kind = ael_pkg::KIND_OP;
            end
            else if (is_brk)
            begin
                cls_emit     = 1'b1;
                cls_tok.kind = ael_pkg::KIND_BRACKET;
            end
            else if (is_digit)
            begin
                mode_next   = MODE_INT;
                nstart_next = pos_reg;
                nlen_next   = 16'd1;
                nfirst_next = text_byte;
            end
            else
            begin
                cls_emit  = 1'b1;
                mode_next = MODE_HALT;
            end
        end

        two_tok = num_emit && cls_emit;
        if (num_emit)
        begin
            first_tok      = num_tok;
            first_tok.last = !cls_emit;
        end
        else
        begin
            first_tok = cls_tok;
        end

        // Held second token goes out first; input is blocked meanwhile
        if (pend_valid_reg)
        begin
            q_wr_en   = !q_full;
            q_wr_data = pend_tok_reg;
        end
        else
        begin
            q_wr_en   = accept && (num_emit || cls_emit);
            q_wr_data = first_tok;
        end

        pend_valid_next = pend_valid_reg;
        pend_tok_next   = pend_tok_reg;
        if (pend_valid_reg && !q_full)
        begin
            pend_valid_next = 1'b0;
        end
        else if (accept && two_tok)
        begin
            pend_valid_next = 1'b1;
            pend_tok_next   = cls_tok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            pos_reg        <= 16'd0;
            nstart_reg     <= 16'd0;
            nlen_reg       <= 16'd0;
            nfirst_reg     <= 8'd0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                nstart_reg <= nstart_next;
                nlen_reg   <= nlen_next;
                nfirst_reg <= nfirst_next;
            end
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_tok_reg <= pend_tok_next;
    end

    `ASSERT_NEXT(a_two_tok_held, clk, rst_n, accept && two_tok, pend_valid_reg && pend_tok_reg.last)
    `ASSERT_NEXT(a_halt_holds_pos, clk, rst_n, accept && (mode_reg == MODE_HALT) && (text_byte != ael_pkg::CH_NUL), $stable(pos_reg) && (mode_reg == MODE_HALT))

endmodule

@@ hw/rtl/ael_queue.sv @@
// ----------------------------------------------------------------------------
// ael_queue
// Small token FIFO between scanner and output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ael_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  ael_pkg::token_t wr_data,
    output logic            q_full,
    input  logic            rd_en,
    output ael_pkg::token_t rd_data,
    output logic            not_empty
);

    ael_pkg::token_t                  slot_reg [ael_pkg::QUEUE_DEPTH];
    logic [ael_pkg::QUEUE_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [ael_pkg::QUEUE_CW-1:0]     count_reg, count_next;

    assign q_full    = (count_reg == ael_pkg::QUEUE_CW'(ael_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `ASSERT_IMPLY(a_no_overflow, clk, rst_n, wr_en, !q_full)
    `ASSERT_IMPLY(a_no_underflow, clk, rst_n, rd_en, not_empty)

endmodule

@@ hw/rtl/ael_back.sv @@
// ----------------------------------------------------------------------------
// ael_back
// Output register: presents the oldest token and retires it on pop.
// ----------------------------------------------------------------------------
module ael_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            not_empty,
    input  ael_pkg::token_t rd_data,
    output logic            rd_en,
    input  logic            pop,
    output logic            empty,
    output ael_pkg::token_t out_tok
);

    logic            out_valid_reg, out_valid_next;
    ael_pkg::token_t out_tok_reg;

    assign empty   = !out_valid_reg;
    assign out_tok = out_tok_reg;
    // Refill if the queue holds a token and the register is free or draining
    assign rd_en   = not_empty && (!out_valid_reg || pop);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (rd_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            out_tok_reg <= rd_data;
        end
    end

endmodule

@@ hw/rtl/arith_expression_lexer_top.sv @@
// Path: a token caused by an accepted byte is written to the queue, then loaded
//   into the output register, which drives the result ports.
// Throughput: one byte per cycle while the queue has room; a byte that closes a
//   number and is itself a token raises full while the scanner writes the second token.
// Reset (rst_n low, asynchronous): scanner idle at offset zero, queue and
//   output register empty.
// ----------------------------------------------------------------------------
// arith_expression_lexer_top
// Streaming tokenizer for arithmetic expressions: bytes in, tokens out.
// ----------------------------------------------------------------------------
module arith_expression_lexer_top
(
    input  logic        clk,
    input  logic        rst_n,
    // Input transaction: push while full is low
    input  logic        push,
    output logic        full,
    input  logic [7:0]  text_byte,
    // Result transaction: pop while empty is low
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic [7:0]  first_char,
    output logic        last_of_run
);

    logic            q_wr_en, q_full;
    logic            q_rd_en, q_not_empty;
    ael_pkg::token_t q_wr_data, q_rd_data, out_tok;

    // Front: classify bytes, hold number state, emit at most one token a cycle
    ael_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .text_byte (text_byte),
        .full      (full),
        .q_full    (q_full),
        .q_wr_en   (q_wr_en),
        .q_wr_data (q_wr_data)
    );

    // Queue: decouple the scanner from result back-pressure
    ael_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (q_wr_en),
        .wr_data   (q_wr_data),
        .q_full    (q_full),
        .rd_en     (q_rd_en),
        .rd_data   (q_rd_data),
        .not_empty (q_not_empty)
    );

    // Back: registered result, advance on pop
    ael_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (q_not_empty),
        .rd_data   (q_rd_data),
        .rd_en     (q_rd_en),
        .pop       (pop),
        .empty     (empty),
        .out_tok   (out_tok)
    );

    assign token_kind   = 2'(out_tok.kind);
    assign token_start  = out_tok.start;
    assign token_length = out_tok.length;
    assign first_char   = out_tok.first;
    assign last_of_run  = out_tok.last;

endmodule

@@ tb/arith_expression_lexer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arith_expression_lexer_checker
// Watches both channels of the lexer, predicts the tokens of each accepted
// byte and compares every accepted token with the oldest prediction.
// ----------------------------------------------------------------------------
module arith_expression_lexer_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [7:0]  text_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  token_kind,
    input  logic [15:0] token_start,
    input  logic [15:0] token_length,
    input  logic [7:0]  first_char,
    input  logic        last_of_run,
    output int          fail_count,
    output int          pending_count,
    output int          byte_count,
    output int          token_count
);

    typedef enum logic [1:0] {
        SCAN_IDLE = 2'd0,
        SCAN_INT  = 2'd1,
        SCAN_FRAC = 2'd2,
        SCAN_HALT = 2'd3
    } scan_mode_t;

    scan_mode_t      scan_mode;
    logic [15:0]     position;
    logic [15:0]     num_start;
    logic [15:0]     num_length;
    logic [7:0]      num_first;
    ael_pkg::token_t expected_tokens[$];

    function automatic bit is_digit(input logic [7:0] b);
        return (b >= ael_pkg::CH_ZERO) && (b <= ael_pkg::CH_NINE);
    endfunction

    function automatic bit is_space(input logic [7:0] b);
        return ((b >= ael_pkg::CH_TAB) && (b <= ael_pkg::CH_CR)) || (b == ael_pkg::CH_SPACE);
    endfunction

    task automatic reset_scanner();
        scan_mode  = SCAN_IDLE;
        position   = '0;
        num_start  = '0;
        num_length = '0;
        num_first  = '0;
    endtask

    task automatic add_token(input ael_pkg::kind_t kind, input logic [15:0] start,
                             input logic [15:0] length, input logic [7:0] first);
        ael_pkg::token_t t;
        t.kind   = kind;
        t.start  = start;
        t.length = length;
        t.first  = first;
        t.last   = 1'b0;
        expected_tokens.push_back(t);
    endtask

    task automatic tokenize_byte(input logic [7:0] b);
        int produced;
        bit consumed;
        produced = expected_tokens.size();
        consumed = 1'b0;
        if (b == ael_pkg::CH_NUL)
        begin
            if ((scan_mode == SCAN_INT) || (scan_mode == SCAN_FRAC))
                add_token(ael_pkg::KIND_NUMBER, num_start, num_length, num_first);
            reset_scanner();
        end
        else if (scan_mode != SCAN_HALT)
        begin
            if (scan_mode != SCAN_IDLE)
            begin
                // extend the number, or close it and classify the byte below
                if (is_digit(b) || ((b == ael_pkg::CH_POINT) && (scan_mode == SCAN_INT)))
                begin
                    if (num_length != ael_pkg::LEN_LIMIT)
                        num_length++;
                    if (b == ael_pkg::CH_POINT)
                        scan_mode = SCAN_FRAC;
                    consumed = 1'b1;
                end
                else
                begin
                    add_token(ael_pkg::KIND_NUMBER, num_start, num_length, num_first);
                    scan_mode = SCAN_IDLE;
                end
            end
            if (!consumed)
            begin
                case (b)
                    ael_pkg::CH_PLUS, ael_pkg::CH_MINUS, ael_pkg::CH_STAR, ael_pkg::CH_SLASH:
                        add_token(ael_pkg::KIND_OP, position, 16'd1, b);
                    ael_pkg::CH_LPAR, ael_pkg::CH_RPAR:
                        add_token(ael_pkg::KIND_BRACKET, position, 16'd1, b);
                    default:
                    begin
                        if (is_digit(b))
                        begin
                            scan_mode  = SCAN_INT;
                            num_start  = position;
                            num_length = 16'd1;
                            num_first  = b;
                        end
                        else if (!is_space(b))
                        begin
                            add_token(ael_pkg::KIND_ERROR, position, 16'd1, b);
                            scan_mode = SCAN_HALT;
                        end
                    end
                endcase
            end
            if (position != ael_pkg::POS_LIMIT)
                position++;
        end
        if (expected_tokens.size() > produced)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        ael_pkg::token_t exp_tok;
        bit              bad;
        if (!rst_n)
        begin
            reset_scanner();
            expected_tokens.delete();
            fail_count    = 0;
            pending_count = 0;
            byte_count    = 0;
            token_count   = 0;
        end
        else
        begin
            // compare first: a token can never leave in the cycle its byte enters
            if (pop && !empty)
            begin
                token_count++;
                if (expected_tokens.size() == 0)
                begin
                    $error("unexpected token: kind %0d start %0d length %0d",
                           token_kind, token_start, token_length);
                    fail_count++;
                end
                else
                begin
                    exp_tok = expected_tokens.pop_front();
                    bad = 1'b0;
                    if (token_kind !== exp_tok.kind)
                    begin
                        $error("token_kind: expected %0d, actual %0d", exp_tok.kind, token_kind);
                        bad = 1'b1;
                    end
                    if (token_start !== exp_tok.start)
                    begin
                        $error("token_start: expected %0d, actual %0d", exp_tok.start,
                               token_start);
                        bad = 1'b1;
                    end
                    if (token_length !== exp_tok.length)
                    begin
                        $error("token_length: expected %0d, actual %0d", exp_tok.length,
                               token_length);
                        bad = 1'b1;
                    end
                    if (first_char !== exp_tok.first)
                    begin
                        $error("first_char: expected 0x%02h, actual 0x%02h", exp_tok.first,
                               first_char);
                        bad = 1'b1;
                    end
                    if (last_of_run !== exp_tok.last)
                    begin
                        $error("last_of_run: expected %0d, actual %0d", exp_tok.last,
                               last_of_run);
                        bad = 1'b1;
                    end
                    if (bad)
                        fail_count++;
                end
            end
            if (push && !full)
            begin
                byte_count++;
                tokenize_byte(text_byte);
            end
            pending_count = expected_tokens.size();
        end
    end

endmodule

@@ tb/tb_arith_expression_lexer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_arith_expression_lexer_top
// Drives text bytes into the lexer and drains its tokens with random gaps,
// back-pressure and a drain pause; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_arith_expression_lexer_top;

    // Traffic shaping
    localparam int IDLE_PCT     = 33;     // percent of idle cycles on each side
    localparam int HOLD_CYCLES  = 400;    // receiver hold-off to fill the block
    localparam int RANDOM_BYTES = 1870;   // stop point of the random part
    localparam int LONG_RUN     = 40;     // digits in the long number
    localparam int DRAIN_CYCLES = 8;      // settle time after the last token
    // No correct run goes this long without a transaction: the hold-off plus
    // a few idle cycles is the longest quiet stretch.
    localparam int STALL_LIMIT  = 4000;

    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_HIGH    = 8'h80;
    localparam logic [7:0] CH_TOP     = 8'hFF;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  text_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [7:0]  first_char;
    logic        last_of_run;

    int fail_count;
    int pending_count;
    int byte_count;
    int token_count;

    // Shared between the sender and the receiver
    bit no_idle;
    bit hold_req;
    // Sender-side bookkeeping
    bit halted;       // an error byte went out; later bytes are ignored
    int sent_bytes;   // bytes that the block acts on

    arith_expression_lexer_top i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .text_byte    (text_byte),
        .empty        (empty),
        .pop          (pop),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .first_char   (first_char),
        .last_of_run  (last_of_run)
    );

    arith_expression_lexer_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .text_byte     (text_byte),
        .empty         (empty),
        .pop           (pop),
        .token_kind    (token_kind),
        .token_start   (token_start),
        .token_length  (token_length),
        .first_char    (first_char),
        .last_of_run   (last_of_run),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .byte_count    (byte_count),
        .token_count   (token_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Offer one byte, idling at random first, and hold it until the block
    // takes it. push stays high into the next call unless that call idles.
    task automatic send_byte(input logic [7:0] b);
        while (!no_idle && ($urandom_range(99) < IDLE_PCT))
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        text_byte <= b;
        @(posedge clk iff !full);
        if (!halted)
            sent_bytes++;
        if (b == ael_pkg::CH_NUL)
            halted = 1'b0;
    endtask

    task automatic send_string(input string s);
        foreach (s[i])
            send_byte(s[i]);
    endtask

    // Drop push and wait until the checker has seen the last byte, so that its tokens
    // are already predicted, then wait for every predicted token to leave.
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // One text: mostly a random mix of numbers, operators, brackets and blanks,
    // usually ended by NUL; sometimes a broken one or plain noise.
    task automatic send_random_text();
        logic [7:0] ch;
        if ($urandom_range(99) < 15)
        begin
            // noise: any byte at all, NUL included
            repeat ($urandom_range(1, 20))
                send_byte(8'($urandom_range(0, 255)));
            return;
        end
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    // number: integer digits, maybe a point and a fraction
                    repeat ($urandom_range(1, 5))
                        send_byte(ael_pkg::CH_ZERO + 8'($urandom_range(9)));
                    if ($urandom_range(2) == 0)
                    begin
                        send_byte(ael_pkg::CH_POINT);
                        repeat ($urandom_range(0, 3))
                            send_byte(ael_pkg::CH_ZERO + 8'($urandom_range(9)));
                        if ($urandom_range(14) == 0)
                        begin
                            send_byte(ael_pkg::CH_POINT);   // second point: error
                            halted = 1'b1;
                        end
                    end
                end
                4, 5, 6:
                begin
                    case ($urandom_range(3))
                        0:       ch = ael_pkg::CH_PLUS;
                        1:       ch = ael_pkg::CH_MINUS;
                        2:       ch = ael_pkg::CH_STAR;
                        default: ch = ael_pkg::CH_SLASH;
                    endcase
                    send_byte(ch);
                end
                7:
                    send_byte($urandom_range(1) ? ael_pkg::CH_LPAR : ael_pkg::CH_RPAR);
                8:
                    send_byte(($urandom_range(5) == 5) ? ael_pkg::CH_SPACE
                              : ael_pkg::CH_TAB + 8'($urandom_range(4)));
                default:
                begin
                    if ($urandom_range(3) == 0)
                    begin
                        // unclassified byte: high half or a letter
                        ch = $urandom_range(1) ? 8'($urandom_range(128, 255))
                                               : CH_LOWER_A + 8'($urandom_range(25));
                        send_byte(ch);
                        halted = 1'b1;
                    end
                    else
                        send_byte(ael_pkg::CH_SPACE);
                end
            endcase
            if (halted)
                break;
        end
        if (halted)
        begin
            // bytes after an error are ignored until NUL
            repeat ($urandom_range(0, 3))
                send_byte(8'($urandom_range(1, 255)));
            send_byte(ael_pkg::CH_NUL);
        end
        else if ($urandom_range(7) != 0)
            send_byte(ael_pkg::CH_NUL);
    endtask

    // Receiver: pop at random, or hold off for a counted stretch on request
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            pop <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run when no transaction happens for too long
    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (push && !full) || (pop && !empty))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        bit hold_done;
        bit pause_done;
        push       = 1'b0;
        text_byte  = ael_pkg::CH_NUL;
        rst_n      = 1'b0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        halted     = 1'b0;
        sent_bytes = 0;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: every operator, both brackets, every whitespace byte, a
        // trailing point, a number closed by an operator or a bracket, and a
        // number flushed by end of text.
        send_string("(12.5+3.)*\t\n\v\f\r 7/-9");
        send_byte(ael_pkg::CH_NUL);
        // second point inside the fraction, then an ignored byte after the error
        send_string("0..");
        send_byte(CH_TOP);
        send_byte(ael_pkg::CH_NUL);
        // high-half byte is an error on its own
        send_byte(CH_HIGH);
        send_byte(ael_pkg::CH_NUL);

        // Random texts, with one receiver hold-off, one drain pause and one
        // stretch without idling on either side
        while (sent_bytes < RANDOM_BYTES)
        begin
            if (!hold_done && (sent_bytes > 500))
            begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && (sent_bytes > 1000))
            begin
                wait_drained();
                pause_done = 1'b1;
            end
            no_idle = (sent_bytes >= 1300) && (sent_bytes < 1600);
            send_random_text();
        end
        send_byte(ael_pkg::CH_NUL);

        // Long number back to back, closed by an operator, then one more
        // number flushed by end of text
        no_idle = 1'b1;
        repeat (LONG_RUN) send_byte(CH_ONE);
        send_byte(ael_pkg::CH_PLUS);
        send_byte(ael_pkg::CH_NINE);
        send_byte(ael_pkg::CH_NUL);
        no_idle = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes in, %0d tokens out: directed cases, random expressions,",
                 byte_count, token_count);
        $display("noise, back-pressure, a drain pause and a %0d-digit number.", LONG_RUN);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
